FILE: hdl/sorted_list_table_top_defines.svh
// Assertion macros for the sorted list table datapath.
`ifndef SORTED_LIST_TABLE_TOP_DEFINES_SVH
`define SORTED_LIST_TABLE_TOP_DEFINES_SVH

// Implication checked at every clock edge out of reset.
`define SLT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted list table assertion failed");

// Invariant checked at every clock edge out of reset.
`define SLT_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("sorted list table assertion failed");

`endif

FILE: hdl/slt_pkg.sv
// Shared types and codes for the sorted list table.
package slt_pkg;

  // Command codes
  localparam logic [1:0] CMD_PUSH_FRONT    = 2'd0;
  localparam logic [1:0] CMD_INSERT_SORTED = 2'd1;
  localparam logic [1:0] CMD_REMOVE        = 2'd2;
  localparam logic [1:0] CMD_SEARCH        = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] position;
    logic [4:0] entry_count;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_SHIFT,
    S_RESP
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic start;
    logic scan;
    logic shift;
    logic out_load;
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [1:0] op;
    logic       full;
    logic       scan_done;
    logic       hit;
    logic       shift_done;
    logic       out_free;
  } dp_sts_t;

endpackage

FILE: hdl/slt_ctrl.sv
// Sequencing state machine for the sorted list table.
module slt_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  slt_pkg::dp_sts_t sts,
  output slt_pkg::ctl_cmd_t cmd
);
  import slt_pkg::*;

  state_t state_r, state_nxt;
  logic   op_ins;

  assign op_ins = (sts.op == CMD_PUSH_FRONT) || (sts.op == CMD_INSERT_SORTED);

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Pick next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_START;
      end
      S_START: begin
        if (op_ins && sts.full) state_nxt = S_RESP;
        else if (sts.op == CMD_PUSH_FRONT) state_nxt = S_SHIFT;
        else state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          if ((sts.op == CMD_SEARCH) || ((sts.op == CMD_REMOVE) && !sts.hit)) begin
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        if (sts.shift_done) state_nxt = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Drive commands
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      S_START: cmd.start    = 1'b1;
      S_SCAN:  cmd.scan     = 1'b1;
      S_SHIFT: cmd.shift    = 1'b1;
      S_RESP:  cmd.out_load = sts.out_free;
      default: in_stall     = 1'b1;
    endcase
  end

endmodule

FILE: hdl/slt_datapath.sv
// Entry memory, scan and shift pointers, count and result register.
`include "sorted_list_table_top_defines.svh"

module slt_datapath #(
  parameter int CAPACITY = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  slt_pkg::in_t      in_data,
  input  logic              out_stall,
  output logic              out_valid,
  output slt_pkg::out_t     out_data,
  input  slt_pkg::ctl_cmd_t cmd,
  output slt_pkg::dp_sts_t  sts
);
  import slt_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic signed [31:0] mem [CAPACITY];

  logic [1:0]         op_r;
  logic signed [31:0] val_r;
  logic signed [31:0] rdata_r;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic [CW-1:0]      rd_idx_r, rd_idx_nxt;
  logic [CW-1:0]      pos_r, pos_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic               found_r, found_nxt;
  logic               full_r, full_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_data_r, out_data_nxt;

  logic               op_ins, full_now, match, hit;
  logic               scan_issue, scan_done, shift_issue, shift_done, out_free;
  logic [CW-1:0]      idx_inc, idx_dec, rd_inc, rd_dec;
  logic               re, we;
  logic [AW-1:0]      raddr, waddr;
  logic signed [31:0] wdata;
  logic [1:0]         res_status;
  logic [31:0]        pos_w, count_w;

  assign op_ins   = (op_r == CMD_PUSH_FRONT) || (op_r == CMD_INSERT_SORTED);
  assign full_now = (count_r == CW'(CAPACITY));
  assign idx_inc  = idx_r + 1'b1;
  assign idx_dec  = idx_r - 1'b1;
  assign rd_inc   = rd_idx_r + 1'b1;
  assign rd_dec   = rd_idx_r - 1'b1;

  // Compare the returned entry: first not-less for insert, first equal otherwise
  assign match      = (op_r == CMD_INSERT_SORTED) ? !(rdata_r < val_r) : (rdata_r == val_r);
  assign hit        = rd_vld_r && match;
  assign scan_issue = !hit && (idx_r < count_r);
  assign scan_done  = hit || (!rd_vld_r && (idx_r == count_r));

  // Shift walks toward the gap: downward for insert, upward for remove
  assign shift_issue = op_ins ? (idx_r > pos_r) : (idx_r < count_r);
  assign shift_done  = !shift_issue && !rd_vld_r;
  assign out_free    = !out_valid_r || !out_stall;

  // Pointer, count and memory port control
  always_comb begin
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    rd_vld_nxt = 1'b0;
    rd_idx_nxt = rd_idx_r;
    pos_nxt    = pos_r;
    found_nxt  = found_r;
    full_nxt   = full_r;
    re         = 1'b0;
    raddr      = idx_r[AW-1:0];
    we         = 1'b0;
    waddr      = pos_r[AW-1:0];
    wdata      = val_r;
    if (cmd.start) begin
      full_nxt  = op_ins && full_now;
      found_nxt = 1'b0;
      pos_nxt   = '0;
      idx_nxt   = (op_r == CMD_PUSH_FRONT) ? count_r : '0;
    end
    if (cmd.scan) begin
      if (scan_issue) begin
        re         = 1'b1;
        raddr      = idx_r[AW-1:0];
        idx_nxt    = idx_inc;
        rd_vld_nxt = 1'b1;
        rd_idx_nxt = idx_r;
      end
      if (scan_done) begin
        pos_nxt   = hit ? rd_idx_r : count_r;
        found_nxt = hit;
        idx_nxt   = op_ins ? count_r : rd_inc;
      end
    end
    if (cmd.shift) begin
      if (op_ins) begin
        if (shift_issue) begin
          re         = 1'b1;
          raddr      = idx_dec[AW-1:0];
          idx_nxt    = idx_dec;
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = idx_dec;
        end
        if (rd_vld_r) begin
          we    = 1'b1;
          waddr = rd_inc[AW-1:0];
          wdata = rdata_r;
        end
        if (shift_done) begin
          we        = 1'b1;
          waddr     = pos_r[AW-1:0];
          wdata     = val_r;
          count_nxt = count_r + 1'b1;
        end
      end else begin
        if (shift_issue) begin
          re         = 1'b1;
          raddr      = idx_r[AW-1:0];
          idx_nxt    = idx_inc;
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = idx_r;
        end
        if (rd_vld_r) begin
          we    = 1'b1;
          waddr = rd_dec[AW-1:0];
          wdata = rdata_r;
        end
        if (shift_done) begin
          count_nxt = count_r - 1'b1;
        end
      end
    end
  end

  // Build the result transaction
  always_comb begin
    pos_w   = 32'(pos_r);
    count_w = 32'(count_r);
    if (full_r) begin
      res_status = ST_FULL;
    end else if (((op_r == CMD_REMOVE) || (op_r == CMD_SEARCH)) && !found_r) begin
      res_status = ST_NOT_FOUND;
    end else begin
      res_status = ST_DONE;
    end
    out_data_nxt.status      = res_status;
    out_data_nxt.position    = (res_status == ST_DONE) ? pos_w[3:0] : 4'd0;
    out_data_nxt.entry_count = count_w[4:0];
    if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) out_valid_nxt = 1'b1;
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_data.cmd;
      val_r <= in_data.value;
    end
    idx_r    <= idx_nxt;
    rd_idx_r <= rd_idx_nxt;
    pos_r    <= pos_nxt;
    found_r  <= found_nxt;
    full_r   <= full_nxt;
    if (cmd.out_load) out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sts.op         = op_r;
  assign sts.full       = full_now;
  assign sts.scan_done  = scan_done;
  assign sts.hit        = hit;
  assign sts.shift_done = shift_done;
  assign sts.out_free   = out_free;

  `SLT_ASSERT_ALWAYS(a_count_bound, count_r <= CW'(CAPACITY))
  `SLT_ASSERT_IMP(a_hit_in_list, cmd.scan && hit, rd_idx_r < count_r)
  `SLT_ASSERT_IMP(a_no_full_shift, cmd.shift && op_ins, count_r < CW'(CAPACITY))

endmodule

FILE: hdl/sorted_list_table_top.sv
// Top level of the sorted list table: sequencing controller joined to the entry datapath.
// Sequence: a setup state, then a scan and a shift, then a load of the result register;
// push front skips the scan, search and a missed remove skip the shift, and a refused
// insert goes from setup straight to the result load.
// One command at a time, accepted again after the result load; out_stall holds the load.
// Reset (rst_n low, synchronous) empties the list; entry storage is not cleared.
module sorted_list_table_top #(
  parameter int CAPACITY = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  slt_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output slt_pkg::out_t out_data
);
  import slt_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  slt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  slt_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

FILE: verif/sorted_list_table_top_test.sv
// Testbench for sorted_list_table_top: model-based scoreboard with random stall and idle traffic.
`timescale 1ns / 1ps

import slt_pkg::*;

// Shadow copy of the list; predicts each response and checks it in order.
class list_tracker #(int DEPTH = 16);
  logic signed [31:0] entries [DEPTH];
  int                 count;
  out_t               pending [$];
  int                 errors;

  function new();
    count  = 0;
    errors = 0;
  endfunction

  // Return index of first entry equal to v, or count if absent
  function int find_value(logic signed [31:0] v);
    int idx;
    idx = 0;
    while (idx < count && entries[idx] != v) idx++;
    return idx;
  endfunction

  // Shift entries toward the tail and place v at position at
  function void open_gap(int at, logic signed [31:0] v);
    for (int k = count; k > at; k--) entries[k] = entries[k - 1];
    entries[at] = v;
    count++;
  endfunction

  // Apply one accepted command to the shadow list and queue its response
  function void record_command(in_t item);
    out_t               rsp;
    int                 idx;
    logic signed [31:0] v;
    v   = $signed(item.value);
    rsp = '0;
    rsp.status = ST_DONE;
    case (item.cmd)
      CMD_PUSH_FRONT: begin
        if (count >= DEPTH) rsp.status = ST_FULL;
        else open_gap(0, v);
      end
      CMD_INSERT_SORTED: begin
        if (count >= DEPTH) begin
          rsp.status = ST_FULL;
        end else begin
          idx = 0;
          while (idx < count && $signed(entries[idx]) < v) idx++;
          open_gap(idx, v);
          rsp.position = idx[3:0];
        end
      end
      CMD_REMOVE: begin
        idx = find_value(v);
        if (idx >= count) begin
          rsp.status = ST_NOT_FOUND;
        end else begin
          for (int k = idx; k + 1 < count; k++) entries[k] = entries[k + 1];
          count--;
          rsp.position = idx[3:0];
        end
      end
      default: begin
        idx = find_value(v);
        if (idx >= count) rsp.status = ST_NOT_FOUND;
        else rsp.position = idx[3:0];
      end
    endcase
    rsp.entry_count = count[4:0];
    pending.push_back(rsp);
  endfunction

  // Compare one response with the oldest prediction
  function void check_response(out_t got);
    out_t exp_rsp;
    if (pending.size() == 0) begin
      $error("unexpected response: status %0d position %0d entry_count %0d",
             got.status, got.position, got.entry_count);
      errors++;
      return;
    end
    exp_rsp = pending.pop_front();
    if (got.status !== exp_rsp.status) begin
      $error("status: expected %0d, actual %0d", exp_rsp.status, got.status);
      errors++;
    end
    if (got.position !== exp_rsp.position) begin
      $error("position: expected %0d, actual %0d", exp_rsp.position, got.position);
      errors++;
    end
    if (got.entry_count !== exp_rsp.entry_count) begin
      $error("entry_count: expected %0d, actual %0d", exp_rsp.entry_count, got.entry_count);
      errors++;
    end
  endfunction
endclass

module sorted_list_table_top_test;

  localparam int LIST_DEPTH   = 16;
  localparam int RANDOM_ITEMS = 950;
  localparam int SEGMENT_LEN  = 24;

  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_ANY} mix_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  int send_idle_pct;
  int recv_stall_pct;

  list_tracker #(LIST_DEPTH) tracker;

  sorted_list_table_top #(.CAPACITY(LIST_DEPTH)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Free-running clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Hold all inputs known from time zero
  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_stall      = 1'b0;
    send_idle_pct  = 25;
    recv_stall_pct = 71;
    tracker        = new();
  end

  // Check each accepted response and pick the next stall at random
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_response(out_data);
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Hang guard
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic in_t make_item(logic [1:0] cmd, logic signed [31:0] value);
    in_t item;
    item.cmd   = cmd;
    item.value = value;
    return item;
  endfunction

  // Offer one transaction, idling first at random, and note it once accepted
  task automatic send_cmd(in_t item);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.record_command(item);
  endtask

  // Pick an operand: often one held in the list, else a corner or a wide random
  function automatic logic signed [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40 && tracker.count > 0)
      return tracker.entries[$urandom_range(0, tracker.count - 1)];
    if (r < 70) begin
      case ($urandom_range(0, 3))
        0:       return 32'sh8000_0000;
        1:       return 32'sh7FFF_FFFF;
        default: return $signed($urandom_range(0, 6)) - 3;
      endcase
    end
    return $urandom;
  endfunction

  // Pick a command weighted by the current segment's mix
  function automatic logic [1:0] pick_cmd(mix_t mix);
    int r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_GROW: begin
        if (r < 15) return CMD_PUSH_FRONT;
        if (r < 70) return CMD_INSERT_SORTED;
        if (r < 85) return CMD_REMOVE;
        return CMD_SEARCH;
      end
      MIX_SHRINK: begin
        if (r < 5)  return CMD_PUSH_FRONT;
        if (r < 20) return CMD_INSERT_SORTED;
        if (r < 80) return CMD_REMOVE;
        return CMD_SEARCH;
      end
      default: return r[1:0];
    endcase
  endfunction

  initial begin
    mix_t mix;
    mix = MIX_ANY;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty list misses, extremes, duplicates, hits and misses
    send_cmd(make_item(CMD_SEARCH, 32'sd0));
    send_cmd(make_item(CMD_REMOVE, 32'sd0));
    send_cmd(make_item(CMD_PUSH_FRONT, 32'sh7FFF_FFFF));
    send_cmd(make_item(CMD_PUSH_FRONT, 32'sh8000_0000));
    send_cmd(make_item(CMD_INSERT_SORTED, -32'sd1));
    send_cmd(make_item(CMD_INSERT_SORTED, -32'sd1));
    send_cmd(make_item(CMD_INSERT_SORTED, 32'sd0));
    send_cmd(make_item(CMD_SEARCH, -32'sd1));
    send_cmd(make_item(CMD_SEARCH, 32'sd5));
    send_cmd(make_item(CMD_REMOVE, 32'sh8000_0000));
    send_cmd(make_item(CMD_REMOVE, 32'sd7));
    send_cmd(make_item(CMD_INSERT_SORTED, 32'sh7FFF_FFFF));
    // Fill up, then hit the full list with both insert kinds
    while (tracker.count < LIST_DEPTH)
      send_cmd(make_item(CMD_INSERT_SORTED, $urandom));
    send_cmd(make_item(CMD_PUSH_FRONT, 32'sd1));
    send_cmd(make_item(CMD_INSERT_SORTED, 32'sd1));
    send_cmd(make_item(CMD_SEARCH, 32'sh7FFF_FFFF));
    send_cmd(make_item(CMD_REMOVE, 32'sh7FFF_FFFF));

    // Random traffic in segments that grow, drain or mix the list
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        send_idle_pct  = 71;
        recv_stall_pct = 25;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      if (n % SEGMENT_LEN == 0) mix = mix_t'($urandom_range(0, 2));
      send_cmd(make_item(pick_cmd(mix), pick_value()));
    end
    in_valid <= 1'b0;

    // Drain outstanding responses, then allow for stray output
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (2 * LIST_DEPTH + 10) @(posedge clk);

    if (tracker.errors == 0 && tracker.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
